// ===== hw/rtl/fnv_ks_pkg.sv =====
// shared types and constants for the fnv-1a key hash and slot select unit
package fnv_ks_pkg;

    localparam int HASH_W  = 32;
    localparam int COUNT_W = 11;
    localparam int SLOT_W  = 10;
    localparam int BYTE_W  = 8;
    localparam int STEP_W  = $clog2(HASH_W);

    localparam logic [HASH_W-1:0]  HASH_BASIS  = 32'd2166136261;
    localparam logic [HASH_W-1:0]  HASH_PRIME  = 32'd16777619;
    localparam logic [BYTE_W-1:0]  SEP_BYTE    = 8'h2F;
    localparam logic [COUNT_W-1:0] MAX_WORKERS = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

    typedef enum logic [1:0] {
        OP_FOLD   = 2'd0,
        OP_SEP    = 2'd1,
        OP_FINISH = 2'd2,
        OP_RSVD   = 2'd3
    } t_opcode;

    // controller to datapath
    typedef struct packed {
        logic fold;
        logic sel_sep;
        logic emit_start;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_last;
    } t_dp_sts;

    function automatic logic [HASH_W-1:0] fold_byte(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
        return x * HASH_PRIME;
    endfunction

endpackage

// ===== hw/rtl/fnv_ks_if.sv =====
// valid/ready channel interfaces for key items and hash results
interface fnv_ks_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] key_byte;
    logic       end_of_key;

    modport source (output valid, output opcode, output key_byte, output end_of_key,
                    input ready);
    modport sink   (input valid, input opcode, input key_byte, input end_of_key,
                    output ready);
endinterface

interface fnv_ks_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] key_hash;
    logic [9:0]  owner_slot;

    modport source (output valid, output key_hash, output owner_slot, input ready);
    modport sink   (input valid, input key_hash, input owner_slot, output ready);
endinterface

// ===== hw/rtl/fnv_ks_ctrl.sv =====
// controller: item decode, divider sequencing and output handshake
module fnv_ks_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_opcode,
    input  logic                i_end_of_key,
    input  logic                i_out_ready,
    input  fnv_ks_pkg::t_dp_sts i_sts,
    output fnv_ks_pkg::t_dp_cmd o_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   in_xfer;

    assign in_xfer = i_in_valid & r_in_ready;

    always_comb begin
        o_cmd = '0;
        unique case (fnv_ks_pkg::t_opcode'(i_opcode))
            fnv_ks_pkg::OP_FOLD: begin
                o_cmd.fold       = in_xfer;
                o_cmd.emit_start = in_xfer & i_end_of_key;
            end
            fnv_ks_pkg::OP_SEP: begin
                o_cmd.fold       = in_xfer;
                o_cmd.sel_sep    = 1'b1;
                o_cmd.emit_start = in_xfer & i_end_of_key;
            end
            fnv_ks_pkg::OP_FINISH: begin
                o_cmd.emit_start = in_xfer;
            end
            default: begin
                // reserved code: no fold, no result
            end
        endcase
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.load_out = (r_state == S_HOLD) & (~r_out_valid | i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.emit_start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (o_cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/fnv_ks_dp.sv =====
// datapath: running hash, bit-serial modulo unit and output registers
module fnv_ks_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fnv_ks_pkg::t_dp_cmd                  i_cmd,
    input  logic [fnv_ks_pkg::BYTE_W-1:0]        i_key_byte,
    input  logic                                 i_cfg_we,
    input  logic [fnv_ks_pkg::COUNT_W-1:0]       i_cfg_wdata,
    output fnv_ks_pkg::t_dp_sts                  o_sts,
    output logic [fnv_ks_pkg::HASH_W-1:0]        o_key_hash,
    output logic [fnv_ks_pkg::SLOT_W-1:0]        o_owner_slot
);

    logic [fnv_ks_pkg::HASH_W-1:0]  r_hash;
    logic [fnv_ks_pkg::COUNT_W-1:0] r_count;
    logic [fnv_ks_pkg::HASH_W-1:0]  r_emit_hash;
    logic [fnv_ks_pkg::HASH_W-1:0]  r_dvd;
    logic [fnv_ks_pkg::SLOT_W-1:0]  r_rem;
    logic [fnv_ks_pkg::COUNT_W-1:0] r_div;
    logic [fnv_ks_pkg::STEP_W-1:0]  r_step;
    logic [fnv_ks_pkg::HASH_W-1:0]  r_out_hash;
    logic [fnv_ks_pkg::SLOT_W-1:0]  r_out_slot;

    logic [fnv_ks_pkg::BYTE_W-1:0]  fold_in;
    logic [fnv_ks_pkg::HASH_W-1:0]  n_fold;
    logic [fnv_ks_pkg::HASH_W-1:0]  emit_val;
    logic [fnv_ks_pkg::COUNT_W-1:0] eff_count;
    logic [fnv_ks_pkg::COUNT_W-1:0] trial;
    logic [fnv_ks_pkg::COUNT_W-1:0] diff;
    logic [fnv_ks_pkg::SLOT_W-1:0]  n_rem;

    assign fold_in   = i_cmd.sel_sep ? fnv_ks_pkg::SEP_BYTE : i_key_byte;
    assign n_fold    = fnv_ks_pkg::fold_byte(r_hash, fold_in);
    assign emit_val  = i_cmd.fold ? n_fold : r_hash;
    assign eff_count = (r_count > fnv_ks_pkg::MAX_WORKERS) ? fnv_ks_pkg::MAX_WORKERS
                                                           : r_count;

    // restoring remainder step, remainder stays below a nonzero divisor
    assign trial = {r_rem, r_dvd[fnv_ks_pkg::HASH_W-1]};
    assign diff  = trial - r_div;
    assign n_rem = (trial >= r_div) ? diff[fnv_ks_pkg::SLOT_W-1:0]
                                    : trial[fnv_ks_pkg::SLOT_W-1:0];

    assign o_sts.div_last = (r_step == {fnv_ks_pkg::STEP_W{1'b1}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= fnv_ks_pkg::HASH_BASIS;
            r_count <= fnv_ks_pkg::COUNT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (i_cmd.emit_start) begin
                r_hash <= fnv_ks_pkg::HASH_BASIS;
            end else if (i_cmd.fold) begin
                r_hash <= n_fold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_start) begin
            r_emit_hash <= emit_val;
            r_dvd       <= emit_val;
            r_rem       <= '0;
            r_div       <= eff_count;
            r_step      <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[fnv_ks_pkg::HASH_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_step <= r_step + {{(fnv_ks_pkg::STEP_W-1){1'b0}}, 1'b1};
        end
        if (i_cmd.load_out) begin
            r_out_hash <= r_emit_hash;
            r_out_slot <= (r_div == '0) ? '0 : r_rem;
        end
    end

    assign o_key_hash   = r_out_hash;
    assign o_owner_slot = r_out_slot;

endmodule

// ===== hw/rtl/fnv1a_key_hash_slot_select_unit.sv =====
// top level of the fnv-1a key hash and owner slot select unit
// Folds a key one item per transfer into a 32-bit FNV-1a hash (basis
// 2166136261, prime 16777619); a separator item folds a '/' byte, opcode 3
// is ignored. Items that fold without ending the key are taken one per
// cycle while no slot calculation is running. An item that ends the key
// (end_of_key on a fold or separator, or any finish) starts the slot
// calculation: the hash is reduced modulo min(worker_count, 1024) by a
// bit-serial remainder unit that takes one hash bit per cycle, so ready
// stays low after such a transfer through the 32 remainder steps and the
// output register load, and the result is valid in the output register
// from the cycle ready returns. The output register holds one result;
// while it waits for its transfer the unit keeps taking new key items,
// and a further key end then waits after its remainder steps, with ready
// low, until the register is free. A worker count of zero gives slot 0.
// worker_count resets to 1; the user writes it through i_cfg_we /
// i_cfg_wdata only while the unit is idle, the block does not enforce it.
module fnv1a_key_hash_slot_select_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    fnv_ks_in_if.sink                            i_key,
    fnv_ks_out_if.source                         o_res,
    input  logic                                 i_cfg_we,
    input  logic [fnv_ks_pkg::COUNT_W-1:0]       i_cfg_wdata
);

    fnv_ks_pkg::t_dp_cmd cmd;
    fnv_ks_pkg::t_dp_sts sts;

    // controller: decodes accepted items, runs the remainder steps and
    // owns both handshake flags
    fnv_ks_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_key.valid),
        .i_opcode     (i_key.opcode),
        .i_end_of_key (i_key.end_of_key),
        .i_out_ready  (o_res.ready),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_in_ready   (i_key.ready),
        .o_out_valid  (o_res.valid)
    );

    // datapath: running hash, worker count register, remainder unit
    // and the result register
    fnv_ks_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_key_byte   (i_key.key_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_sts        (sts),
        .o_key_hash   (o_res.key_hash),
        .o_owner_slot (o_res.owner_slot)
    );

endmodule

// ===== hw/rtl/fnv_ks_chk.sv =====
// port-level checker for the key hash slot select unit, with its bind
module fnv_ks_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic [1:0]                           i_opcode,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic [fnv_ks_pkg::HASH_W-1:0]        i_key_hash,
    input logic [fnv_ks_pkg::SLOT_W-1:0]        i_owner_slot,
    input logic                                 i_cfg_we,
    input logic [fnv_ks_pkg::COUNT_W-1:0]       i_cfg_wdata
);

    logic [fnv_ks_pkg::COUNT_W-1:0] r_count;

    // shadow of the worker count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= fnv_ks_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_key_hash) && $stable(i_owner_slot))
        else $error("result changed while stalled");

    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_opcode == fnv_ks_pkg::OP_FINISH |=> !i_in_ready)
        else $error("finish transfer did not start the slot calculation");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_count != '0 && r_count <= fnv_ks_pkg::MAX_WORKERS |->
            {1'b0, i_owner_slot} < r_count)
        else $error("owner slot not below worker count");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_count == '0 |-> i_owner_slot == '0)
        else $error("zero worker count gave nonzero slot");

endmodule

bind fnv1a_key_hash_slot_select_unit fnv_ks_chk u_fnv_ks_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_key.valid),
    .i_in_ready   (i_key.ready),
    .i_opcode     (i_key.opcode),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_key_hash   (o_res.key_hash),
    .i_owner_slot (o_res.owner_slot),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_wdata  (i_cfg_wdata)
);

// ===== tb/fnv1a_key_hash_slot_select_unit_test.sv =====
// self-checking testbench for the fnv-1a key hash and owner slot select unit
module fnv1a_key_hash_slot_select_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // hash constants kept local to the predictor
    localparam logic [fnv_ks_pkg::HASH_W-1:0]  FNV_OFFSET     = 32'h811C_9DC5;
    localparam logic [fnv_ks_pkg::HASH_W-1:0]  FNV_PRIME      = 32'h0100_0193;
    localparam logic [fnv_ks_pkg::BYTE_W-1:0]  SLASH_BYTE     = 8'h2F;
    localparam logic [fnv_ks_pkg::COUNT_W-1:0] SLOT_CAP       = 11'd1024;
    // settle margin covering the remainder unit's steps plus the output register load
    localparam int                             SETTLE_CYCLES  = 40;
    localparam int                             ITEMS_PER_LOOP = 143;
    localparam int                             MAX_REPORTS    = 10;

    typedef struct packed {
        fnv_ks_pkg::t_opcode           op;
        logic [fnv_ks_pkg::BYTE_W-1:0] kbyte;
        logic                          eok;
    } t_key_item;

    typedef struct packed {
        logic [fnv_ks_pkg::HASH_W-1:0] hash;
        logic [fnv_ks_pkg::SLOT_W-1:0] slot;
    } t_hash_result;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [fnv_ks_pkg::COUNT_W-1:0]   i_cfg_wdata;

    fnv_ks_in_if  key_if ();
    fnv_ks_out_if res_if ();

    fnv1a_key_hash_slot_select_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (key_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // stimulus waiting for the driver, and hash results still owed by the unit
    t_key_item    key_items_q[$];
    t_hash_result hash_results_q[$];

    // predictor state: running hash and shadow of the worker count register
    logic [fnv_ks_pkg::HASH_W-1:0]  hash_acc;
    logic [fnv_ks_pkg::COUNT_W-1:0] worker_count_cfg;

    int unsigned fail_count;
    int unsigned loop_items;

    // driver / receiver bookkeeping
    bit          key_taken;
    bit          send_burst;
    bit          take_burst;
    int unsigned send_gap;
    int unsigned take_stall;
    t_key_item   next_item;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case the unit hangs
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // one fnv-1a round: xor the byte in, then multiply mod 2^32
    function automatic logic [fnv_ks_pkg::HASH_W-1:0] fnv_mix(
        input logic [fnv_ks_pkg::HASH_W-1:0] h,
        input logic [fnv_ks_pkg::BYTE_W-1:0] b
    );
        logic [fnv_ks_pkg::HASH_W-1:0] x;
        x = h ^ {{(fnv_ks_pkg::HASH_W-fnv_ks_pkg::BYTE_W){1'b0}}, b};
        return x * FNV_PRIME;
    endfunction

    // counts above 1024 saturate, zero count maps every key to slot zero
    function automatic logic [fnv_ks_pkg::SLOT_W-1:0] owner_of(
        input logic [fnv_ks_pkg::HASH_W-1:0]  h,
        input logic [fnv_ks_pkg::COUNT_W-1:0] cnt
    );
        logic [fnv_ks_pkg::HASH_W-1:0] c;
        c = (cnt > SLOT_CAP) ? fnv_ks_pkg::HASH_W'(SLOT_CAP) : fnv_ks_pkg::HASH_W'(cnt);
        if (c == 0) begin
            return '0;
        end
        return fnv_ks_pkg::SLOT_W'(h % c);
    endfunction

    // advance the running hash for one accepted key item, queue any emitted result
    task automatic absorb_key_item(input t_key_item it);
        bit           emit;
        t_hash_result res;
        emit = 1'b0;
        case (it.op)
            fnv_ks_pkg::OP_FOLD: begin
                hash_acc = fnv_mix(hash_acc, it.kbyte);
                emit     = it.eok;
            end
            fnv_ks_pkg::OP_SEP: begin
                // key_byte is don't-care here, the slash is folded instead
                hash_acc = fnv_mix(hash_acc, SLASH_BYTE);
                emit     = it.eok;
            end
            fnv_ks_pkg::OP_FINISH: begin
                emit = 1'b1;
            end
            default: begin
                // reserved opcode leaves the hash alone and never emits
                emit = 1'b0;
            end
        endcase
        if (emit) begin
            res.hash = hash_acc;
            res.slot = owner_of(hash_acc, worker_count_cfg);
            hash_results_q.push_back(res);
            hash_acc = FNV_OFFSET;
        end
    endtask

    task automatic note_mismatch(input string what,
                                 input logic [fnv_ks_pkg::HASH_W-1:0] exp_v,
                                 input logic [fnv_ks_pkg::HASH_W-1:0] act_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] %s mismatch: expected 0x%08h, got 0x%08h", $realtime, what,
                     exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------
    // idle shaping: mostly short gaps, a few long ones, and burst stretches
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap(input bit burst);
        int unsigned r;
        if (burst) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // monitor: sample both channels at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_taken = 1'b0;
        end else begin
            // key side transfer feeds the predictor
            key_taken = key_if.valid && key_if.ready;
            if (key_taken) begin
                absorb_key_item('{op: fnv_ks_pkg::t_opcode'(key_if.opcode),
                                  kbyte: key_if.key_byte,
                                  eok: key_if.end_of_key});
            end

            // result side transfer is checked against the oldest expectation
            if (res_if.valid && res_if.ready) begin
                if (hash_results_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("[%0t] unexpected result: hash 0x%08h slot %0d", $realtime,
                                 res_if.key_hash, res_if.owner_slot);
                    end
                end else begin
                    if (res_if.key_hash !== hash_results_q[0].hash) begin
                        note_mismatch("key_hash", hash_results_q[0].hash, res_if.key_hash);
                    end
                    if (res_if.owner_slot !== hash_results_q[0].slot) begin
                        note_mismatch("owner_slot",
                                      fnv_ks_pkg::HASH_W'(hash_results_q[0].slot),
                                      fnv_ks_pkg::HASH_W'(res_if.owner_slot));
                    end
                    void'(hash_results_q.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: key items change at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            key_if.valid <= 1'b0;
        end else if (key_if.valid && !key_taken) begin
            // hold the item until the unit takes it
        end else if (send_gap > 0) begin
            send_gap--;
            key_if.valid <= 1'b0;
        end else if (key_items_q.size() > 0) begin
            next_item = key_items_q.pop_front();
            key_if.opcode     <= next_item.op;
            key_if.key_byte   <= next_item.kbyte;
            key_if.end_of_key <= next_item.eok;
            key_if.valid      <= 1'b1;
            if ($urandom_range(0, 59) == 0) begin
                send_burst = ~send_burst;
            end
            send_gap = pick_gap(send_burst);
        end else begin
            key_if.valid <= 1'b0;
        end
    end

    // receiver: random back-pressure on the result channel
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (take_stall > 0) begin
            take_stall--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 59) == 0) begin
                take_burst = ~take_burst;
            end
            take_stall = pick_gap(take_burst);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input fnv_ks_pkg::t_opcode op,
                             input logic [fnv_ks_pkg::BYTE_W-1:0] b, input logic eok);
        key_items_q.push_back('{op: op, kbyte: b, eok: eok});
    endtask

    // register write, only while the unit is idle
    task automatic set_worker_count(input logic [fnv_ks_pkg::COUNT_W-1:0] cnt);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cnt;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        worker_count_cfg = cnt;
    endtask

    // head part, optional slash, tail part, then either end_of_key or a finish;
    // reserved items are sprinkled in as noise
    task automatic push_random_key();
        t_key_item parts[$];
        t_key_item it;
        int        n_head;
        int        n_tail;
        n_head = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        n_tail = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        for (int i = 0; i < n_head; i++) begin
            parts.push_back('{op: fnv_ks_pkg::OP_FOLD, kbyte: 8'($urandom), eok: 1'b0});
        end
        if ($urandom_range(0, 7) != 0) begin
            parts.push_back('{op: fnv_ks_pkg::OP_SEP, kbyte: 8'($urandom), eok: 1'b0});
        end
        for (int i = 0; i < n_tail; i++) begin
            parts.push_back('{op: fnv_ks_pkg::OP_FOLD, kbyte: 8'($urandom), eok: 1'b0});
        end
        // broken sequence: key cut short somewhere in the middle
        if (parts.size() > 1 && $urandom_range(0, 9) == 0) begin
            parts[$urandom_range(0, parts.size() - 2)].eok = 1'b1;
        end
        if (parts.size() > 0 && $urandom_range(0, 1) == 1) begin
            it = parts.pop_back();
            it.eok = 1'b1;
            parts.push_back(it);
        end else begin
            parts.push_back('{op: fnv_ks_pkg::OP_FINISH, kbyte: 8'($urandom),
                              eok: 1'($urandom)});
        end
        foreach (parts[i]) begin
            if ($urandom_range(0, 11) == 0) begin
                push_item(fnv_ks_pkg::OP_RSVD, 8'($urandom), 1'($urandom));
                loop_items++;
            end
            key_items_q.push_back(parts[i]);
            loop_items++;
        end
    endtask

    task automatic run_random_keys();
        loop_items = 0;
        while (loop_items < ITEMS_PER_LOOP) begin
            push_random_key();
        end
    endtask

    // wait until every item is taken and every result has come back
    task automatic wait_idle();
        while (key_items_q.size() != 0 || key_if.valid || hash_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [fnv_ks_pkg::COUNT_W-1:0] worker_plan[8];

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        key_if.valid      = 1'b0;
        key_if.opcode     = fnv_ks_pkg::OP_FOLD;
        key_if.key_byte   = '0;
        key_if.end_of_key = 1'b0;
        res_if.ready      = 1'b0;
        hash_acc          = FNV_OFFSET;
        worker_count_cfg  = fnv_ks_pkg::COUNT_RESET;
        fail_count        = 0;
        key_taken         = 1'b0;
        send_burst        = 1'b0;
        take_burst        = 1'b0;
        send_gap          = 0;
        take_stall        = 0;

        // zero, cap, saturation above the cap, small and mid counts, back to one
        worker_plan = '{11'd0, 11'd1024, 11'd2047, 11'd1025, 11'd3,
                        11'($urandom_range(2, 1023)), 11'd1000, 11'd1};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed keys at the reset worker count
        push_item(fnv_ks_pkg::OP_FINISH, 8'h00, 1'b0);  // empty key gives the offset basis
        push_item(fnv_ks_pkg::OP_FINISH, 8'hFF, 1'b1);  // finish ignores its byte
        push_item(fnv_ks_pkg::OP_FOLD,   8'h00, 1'b0);
        push_item(fnv_ks_pkg::OP_FOLD,   8'hFF, 1'b1);  // extremes of the byte, ended by flag
        push_item(fnv_ks_pkg::OP_SEP,    8'hA5, 1'b1);  // key made of the slash alone
        push_item(fnv_ks_pkg::OP_RSVD,   8'hFF, 1'b1);  // reserved opcode does nothing
        push_item(fnv_ks_pkg::OP_RSVD,   8'h00, 1'b0);
        push_item(fnv_ks_pkg::OP_FINISH, 8'h5A, 1'b0);  // still the offset basis
        push_item(fnv_ks_pkg::OP_FOLD,   8'h61, 1'b0);
        push_item(fnv_ks_pkg::OP_RSVD,   8'h3C, 1'b1);  // reserved item inside a key
        push_item(fnv_ks_pkg::OP_FOLD,   8'h62, 1'b0);
        push_item(fnv_ks_pkg::OP_SEP,    8'h00, 1'b0);
        push_item(fnv_ks_pkg::OP_FOLD,   8'h80, 1'b0);
        push_item(fnv_ks_pkg::OP_FOLD,   8'h7F, 1'b1);
        push_item(fnv_ks_pkg::OP_FOLD,   8'h55, 1'b0);
        push_item(fnv_ks_pkg::OP_FOLD,   8'hAA, 1'b0);
        push_item(fnv_ks_pkg::OP_SEP,    8'hFF, 1'b0);
        push_item(fnv_ks_pkg::OP_FINISH, 8'h01, 1'b1);
        wait_idle();

        run_random_keys();
        wait_idle();

        foreach (worker_plan[i]) begin
            set_worker_count(worker_plan[i]);
            run_random_keys();
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
